### rtl/mctt_pkg.sv
// shared types and constants for the multi-channel tick timer
`timescale 1ns / 1ps
package mctt_pkg;

  localparam int OP_W        = 2;
  localparam int CH_W        = 5;
  localparam int PER_W       = 16;
  localparam int MAX_RESULTS = 32;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  typedef enum logic [OP_W-1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2,
    OP_SET   = 2'd3
  } op_t;

endpackage

### rtl/multi_channel_tick_timer_core.sv
// multi-channel tick timer: channel memories, walk sequencer and result register
//
// Usage: a command transaction (operation, channel, period_ticks, periodic) is
// taken at a rising edge with start high and busy low. Set period and stop are
// written the same cycle and leave busy low. Start reads the period and writes
// the remaining count, holding busy for 1 cycle. Tick walks all CHANNELS
// entries through the count and period memories, one channel per cycle
// (one read port, one write port), and busy stays high for the whole walk,
// including the registered read of the last channel and a final drain step.
// Each expired channel shows up on expired_channel for one cycle with
// strobe high, in ascending order, the final one with last high in the first
// cycle with busy low. Each expiry is held back until the next expiry is found
// or the walk ends, so the gap between results follows the channel spacing.
// At most MAX_RESULTS expiries are reported per tick.
// The receiver cannot stall: strobe is a one-cycle pulse and must be taken.
// Reset starts a clearing pass over all CHANNELS entries that zeroes every
// count, period and periodic flag; busy stays high until it ends.
`timescale 1ns / 1ps
module multi_channel_tick_timer_core #(
  parameter int CHANNELS    = 32,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [mctt_pkg::OP_W-1:0]     operation,
  input  logic [mctt_pkg::CH_W-1:0]     channel,
  input  logic [mctt_pkg::PER_W-1:0]    period_ticks,
  input  logic                          periodic,
  output logic                          strobe,
  output logic [mctt_pkg::CH_W-1:0]     expired_channel,
  output logic                          last
);
  import mctt_pkg::*;

  localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PW = $clog2(CHANNELS + 1);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_LOAD, S_TICK} state_t;

  state_t                 state;
  logic [PW-1:0]          ptr;
  logic                   proc_valid;
  logic [IW-1:0]          proc_idx;
  logic                   has_pend;
  logic [IW-1:0]          pend_idx;
  logic [CNT_W-1:0]       count;
  logic [IW-1:0]          op_ch;

  logic [COUNT_WIDTH-1:0] rem_mem [CHANNELS];
  logic [COUNT_WIDTH:0]   per_mem [CHANNELS];
  logic [COUNT_WIDTH-1:0] rem_q;
  logic [COUNT_WIDTH-1:0] per_q;
  logic                   en_q;

  logic [IW-1:0]          rd_addr;
  logic                   rem_we;
  logic [IW-1:0]          rem_wa;
  logic [COUNT_WIDTH-1:0] rem_wd;
  logic                   per_we;
  logic [IW-1:0]          per_wa;
  logic [COUNT_WIDTH:0]   per_wd;

  logic                   accept;
  logic                   in_range;
  logic [COUNT_WIDTH-1:0] dec;
  logic                   running;
  logic                   expire;
  logic                   walk_done;

  assign busy      = (state != S_IDLE);
  assign accept    = start && (state == S_IDLE);
  assign in_range  = (32'(channel) < CHANNELS);
  assign dec       = rem_q - COUNT_WIDTH'(1);
  assign running   = proc_valid && (rem_q != '0);
  assign expire    = running && (dec == '0);
  assign walk_done = (ptr == PW'(CHANNELS)) && !proc_valid;

  // memory address and write port selection
  always_comb begin
    rd_addr = ptr[IW-1:0];
    rem_we  = 1'b0;
    rem_wa  = proc_idx;
    rem_wd  = dec;
    per_we  = 1'b0;
    per_wa  = IW'(channel);
    per_wd  = {periodic, COUNT_WIDTH'(period_ticks)};
    unique case (state)
      S_CLEAR: begin
        rem_we = 1'b1;
        rem_wa = ptr[IW-1:0];
        rem_wd = '0;
        per_we = 1'b1;
        per_wa = ptr[IW-1:0];
        per_wd = '0;
      end
      S_IDLE: begin
        rd_addr = IW'(channel);
        if (accept && in_range) begin
          if (op_t'(operation) == OP_STOP) begin
            rem_we = 1'b1;
            rem_wa = IW'(channel);
            rem_wd = '0;
          end
          if (op_t'(operation) == OP_SET) begin
            per_we = 1'b1;
          end
        end
      end
      S_LOAD: begin
        rem_we = 1'b1;
        rem_wa = op_ch;
        rem_wd = per_q;
      end
      S_TICK: begin
        rem_we = running;
        rem_wa = proc_idx;
        if (expire) begin
          rem_wd = en_q ? per_q : '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rem_we) begin
      rem_mem[rem_wa] <= rem_wd;
    end
    rem_q <= rem_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (per_we) begin
      per_mem[per_wa] <= per_wd;
    end
    {en_q, per_q} <= per_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      ptr        <= '0;
      proc_valid <= 1'b0;
      has_pend   <= 1'b0;
      count      <= '0;
      strobe     <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          strobe <= 1'b0;
          ptr    <= ptr + PW'(1);
          if (ptr == PW'(CHANNELS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          strobe <= 1'b0;
          op_ch  <= IW'(channel);
          if (accept) begin
            unique case (op_t'(operation))
              OP_TICK: begin
                state    <= S_TICK;
                ptr      <= '0;
                has_pend <= 1'b0;
                count    <= '0;
              end
              OP_START: begin
                if (in_range) begin
                  state <= S_LOAD;
                end
              end
              OP_STOP, OP_SET: begin
              end
              default: begin
              end
            endcase
          end
        end
        S_LOAD: begin
          strobe <= 1'b0;
          state  <= S_IDLE;
        end
        S_TICK: begin
          if (ptr != PW'(CHANNELS)) begin
            proc_valid <= 1'b1;
            proc_idx   <= ptr[IW-1:0];
            ptr        <= ptr + PW'(1);
          end else begin
            proc_valid <= 1'b0;
          end
          strobe <= has_pend &&
                    ((expire && (count != CNT_W'(MAX_RESULTS))) || walk_done);
          // hold one expiry back so the final one can carry last
          if (expire && (count != CNT_W'(MAX_RESULTS))) begin
            has_pend <= 1'b1;
            pend_idx <= proc_idx;
            count    <= count + CNT_W'(1);
            if (has_pend) begin
              expired_channel <= CH_W'(pend_idx);
              last            <= 1'b0;
            end
          end
          if (walk_done) begin
            state <= S_IDLE;
            if (has_pend) begin
              expired_channel <= CH_W'(pend_idx);
              last            <= 1'b1;
            end
          end
        end
        default: begin
          strobe <= 1'b0;
          state  <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/mctt_checker.sv
// port-level checks for the multi-channel tick timer, bound to the timer core module
`timescale 1ns / 1ps
module mctt_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      start,
  input logic                      busy,
  input logic [mctt_pkg::OP_W-1:0] operation,
  input logic                      strobe,
  input logic                      last
);
  import mctt_pkg::*;

  // reset always starts the clearing pass
  a_reset_busy: assert property (@(posedge clk) rst |=> busy)
    else $error("busy low after reset");

  // results only come out of a tick walk
  a_strobe_from_walk: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy))
    else $error("result without a preceding walk");

  // the final result of a tick ends the walk, earlier ones come during it
  a_last_ends_walk: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (last == !busy))
    else $error("last marker out of step with busy");

  // commands other than tick produce no result
  a_cmd_no_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (operation != OP_TICK)) |=> !strobe)
    else $error("result after a non-tick transaction");

endmodule

bind multi_channel_tick_timer_core mctt_checker u_mctt_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .operation (operation),
  .strobe    (strobe),
  .last      (last)
);

### verif/tb.sv
// testbench for the multi-channel tick timer core: expiry prediction and checking
`timescale 1ns / 1ps
module tb;
  import mctt_pkg::*;

  localparam int CHANNELS    = 32;
  localparam int COUNT_WIDTH = 16;
  localparam int SETTLE      = CHANNELS + 4;
  localparam int DRAIN_LIMIT = 4000;
  localparam int ITEM_BUDGET = 130;

  class expiry_book;
    typedef struct packed {
      logic [CH_W-1:0] ch;
      logic            last;
    } expiry_t;

    logic [COUNT_WIDTH-1:0] count_left [CHANNELS];
    logic [COUNT_WIDTH-1:0] reload_per [CHANNELS];
    logic                   auto_reload[CHANNELS];
    expiry_t                due_q[$];
    int                     errors;

    function new();
      for (int i = 0; i < CHANNELS; i++) begin
        count_left[i]  = '0;
        reload_per[i]  = '0;
        auto_reload[i] = 1'b0;
      end
      errors = 0;
    endfunction

    function int pending();
      return due_q.size();
    endfunction

    function void note_command(op_t op, logic [CH_W-1:0] ch, logic [PER_W-1:0] per,
                               logic pf);
      int hits[$];
      if (op != OP_TICK) begin
        if (ch >= CHANNELS) return;
        case (op)
          OP_START: count_left[ch] = reload_per[ch];
          OP_STOP:  count_left[ch] = '0;
          default: begin
            reload_per[ch]  = per[COUNT_WIDTH-1:0];
            auto_reload[ch] = pf;
          end
        endcase
        return;
      end
      for (int i = 0; i < CHANNELS; i++) begin
        if (count_left[i] != 0) begin
          count_left[i] = count_left[i] - 1'b1;
          if (count_left[i] == 0) begin
            if (hits.size() < MAX_RESULTS) hits.push_back(i);
            if (auto_reload[i]) count_left[i] = reload_per[i];
          end
        end
      end
      for (int k = 0; k < hits.size(); k++)
        due_q.push_back({hits[k][CH_W-1:0], k == hits.size() - 1});
    endfunction

    function void check_result(logic [CH_W-1:0] ch, logic last_flag);
      expiry_t want;
      if (due_q.size() == 0) begin
        $display("%0t unexpected expiry: expected none, got ch %0d last %0d",
                 $time, ch, last_flag);
        errors++;
        return;
      end
      want = due_q.pop_front();
      if (ch !== want.ch) begin
        $display("%0t expired_channel: expected %0d, got %0d", $time, want.ch, ch);
        errors++;
      end
      if (last_flag !== want.last) begin
        $display("%0t last: expected %0d, got %0d", $time, want.last, last_flag);
        errors++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic [OP_W-1:0]   operation = OP_TICK;
  logic [CH_W-1:0]   channel = '0;
  logic [PER_W-1:0]  period_ticks = '0;
  logic              periodic = 1'b0;
  logic              strobe;
  logic [CH_W-1:0]   expired_channel;
  logic              last;

  expiry_book expiries;
  int         items_sent = 0;

  multi_channel_tick_timer_core #(
    .CHANNELS   (CHANNELS),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .operation      (operation),
    .channel        (channel),
    .period_ticks   (period_ticks),
    .periodic       (periodic),
    .strobe         (strobe),
    .expired_channel(expired_channel),
    .last           (last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy)
        expiries.note_command(op_t'(operation), channel, period_ticks, periodic);
      if (strobe) expiries.check_result(expired_channel, last);
    end
  end

  task automatic send_cmd(input op_t op, input logic [CH_W-1:0] ch,
                          input logic [PER_W-1:0] per, input logic pf);
    int gap;
    gap = $urandom_range(0, 5);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    operation    <= op;
    channel      <= ch;
    period_ticks <= per;
    periodic     <= pf;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
  endtask

  task automatic drain();
    int waited;
    waited = 0;
    start <= 1'b0;
    @(posedge clk);
    while (expiries.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic arm_channel(input logic [CH_W-1:0] ch);
    logic [PER_W-1:0] per;
    if ($urandom_range(0, 7) == 0) per = PER_W'($urandom);
    else per = PER_W'($urandom_range(1, 6));
    send_cmd(OP_SET, ch, per, 1'($urandom));
    send_cmd(OP_START, ch, PER_W'($urandom), 1'($urandom));
    repeat ($urandom_range(1, 4)) send_cmd(OP_TICK, CH_W'($urandom), PER_W'($urandom),
                                          1'($urandom));
  endtask

  task automatic burst_all();
    for (int i = 0; i < CHANNELS; i++)
      send_cmd(OP_SET, CH_W'(i), PER_W'(1), i[0]);
    for (int i = 0; i < CHANNELS; i++)
      send_cmd(OP_START, CH_W'(i), '0, 1'b0);
    send_cmd(OP_TICK, '0, '0, 1'b0);
    send_cmd(OP_TICK, '0, '0, 1'b0);
  endtask

  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    bit burst_done;
    expiries = new();
    burst_done = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_cmd(OP_TICK, 5'd0, 16'h0000, 1'b0);
    send_cmd(OP_SET, 5'd0, 16'd1, 1'b1);
    send_cmd(OP_SET, 5'd31, 16'd1, 1'b0);
    send_cmd(OP_SET, 5'd5, 16'd0, 1'b1);
    send_cmd(OP_START, 5'd5, 16'hffff, 1'b1);
    send_cmd(OP_START, 5'd0, 16'h0000, 1'b0);
    send_cmd(OP_START, 5'd31, 16'h0000, 1'b0);
    send_cmd(OP_TICK, 5'd31, 16'hffff, 1'b1);
    send_cmd(OP_TICK, 5'd0, 16'h0000, 1'b0);
    send_cmd(OP_STOP, 5'd0, 16'h0000, 1'b0);
    send_cmd(OP_TICK, 5'd0, 16'h0000, 1'b0);
    send_cmd(OP_SET, 5'd7, 16'hffff, 1'b0);
    send_cmd(OP_START, 5'd7, 16'h0000, 1'b0);
    send_cmd(OP_SET, 5'd3, 16'd2, 1'b1);
    send_cmd(OP_START, 5'd3, 16'h0000, 1'b0);
    // period cleared while running: reload of zero leaves it stopped
    send_cmd(OP_SET, 5'd3, 16'd0, 1'b1);
    send_cmd(OP_TICK, 5'd0, 16'h0000, 1'b0);
    send_cmd(OP_TICK, 5'd0, 16'h0000, 1'b0);
    send_cmd(OP_TICK, 5'd0, 16'h0000, 1'b0);
    send_cmd(OP_START, 5'd9, 16'h0000, 1'b0);
    send_cmd(OP_STOP, 5'd7, 16'h0000, 1'b0);
    send_cmd(OP_SET, 5'd21, 16'h5555, 1'b1);
    drain();

    while (items_sent < ITEM_BUDGET) begin
      if (!burst_done && items_sent > 50) begin
        drain();
        burst_all();
        burst_done = 1'b1;
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: arm_channel(CH_W'($urandom));
        6: send_cmd(op_t'($urandom_range(0, 3)), CH_W'($urandom), PER_W'($urandom),
                    1'($urandom));
        7: begin
          send_cmd(OP_STOP, CH_W'($urandom), PER_W'($urandom), 1'($urandom));
          send_cmd(OP_TICK, CH_W'($urandom), PER_W'($urandom), 1'($urandom));
        end
        8: send_cmd(OP_TICK, CH_W'($urandom), PER_W'($urandom), 1'($urandom));
        default: drain();
      endcase
    end

    drain();
    if (expiries.errors == 0 && expiries.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
